[src/lpr_pkg.sv]
// Shared types for the LRU page replacement block: word structs and controller commands.
package lpr_pkg;

	// Fixed field widths of the request and response words
	localparam int unsigned PAGE_W  = 32;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned CFG_W   = 5;

	// Reset value of the active entry count
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

	// Request word
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              start_new;
		logic              last_request;
	} req_t;

	// Response word
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [COUNT_W-1:0] miss_count;
		logic               run_done;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // capture request word, apply start_new clear
		logic lookup;   // tag compare and slot choice
		logic update;   // table write, recency update, load response register
	} cmd_t;

endpackage

[src/lru_page_replacement.sv]
// Top level of the fully associative LRU page replacement block.
//
//  channel  | handshake            | word                 | direction
//  ---------+----------------------+----------------------+----------
//  request  | req_valid/req_stall  | req (lpr_pkg::req_t) | in
//  response | rsp_valid/rsp_stall  | rsp (lpr_pkg::rsp_t) | out
//  config   | cfg_wr_en            | cfg_wr_data (5 bits) | in
//
// Each word passes through a lookup step for the parallel tag compare and
// victim pick, then an update step for the tag write and rank update. A new
// word is taken in the update step of the previous one.
// arst_n clears ranks, fill count, miss count and sets the active count to 16.
// A stalled response holds the update step, and with it the request side.
module lru_page_replacement #(
	parameter int unsigned ENTRIES   = 16,
	parameter int unsigned PAGE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lpr_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lpr_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lpr_pkg::rsp_t             rsp
);
	import lpr_pkg::*;

	cmd_t cmd;

	// Sequencer
	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Table and response datapath
	lpr_dp #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.req         (req),
		.rsp         (rsp)
	);

endmodule

[src/lpr_ctrl.sv]
// Controller state machine: request acceptance, step sequencing and response valid.
module lpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lpr_pkg::cmd_t cmd
);
	import lpr_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       rsp_valid_q;
	logic       rsp_free;
	logic       finish;
	logic       accept;

	// Response register is free when empty or being taken this cycle
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == ST_UPDATE) && rsp_free;
	assign req_stall = !((state_q == ST_IDLE) || finish);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	assign cmd.accept = accept;
	assign cmd.lookup = (state_q == ST_LOOKUP);
	assign cmd.update = finish;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_nxt = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (finish)
					state_nxt = accept ? ST_LOOKUP : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and response valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (finish)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

[src/lpr_dp.sv]
// Datapath: page tags, age ranks, fill and miss counters, tag compare, victim pick, response.
module lpr_dp #(
	parameter int unsigned ENTRIES   = 16,
	parameter int unsigned PAGE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lpr_pkg::CFG_W-1:0] cfg_wr_data,
	input  lpr_pkg::cmd_t             cmd,
	input  lpr_pkg::req_t             req,
	output lpr_pkg::rsp_t             rsp
);
	import lpr_pkg::*;

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned AGE_W = IDX_W;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// Table state
	logic [PAGE_BITS-1:0] page_q [ENTRIES];
	logic [AGE_W-1:0]     age_q  [ENTRIES];
	logic [AGE_W-1:0]     age_nxt[ENTRIES];
	logic [CNT_W-1:0]     filled_q;
	logic [COUNT_W-1:0]   misses_q;
	logic [COUNT_W-1:0]   misses_nxt;
	logic [CFG_W-1:0]     active_q;

	// Captured request
	logic [PAGE_BITS-1:0] req_page_q;
	logic                 req_last_q;

	// Lookup results
	logic                 hit_s1;
	logic                 fill_s1;
	logic [IDX_W-1:0]     slot_s1;

	logic [CAP_W-1:0]     act_ext;
	logic [CNT_W-1:0]     cap;
	logic [ENTRIES-1:0]   match;
	logic [ENTRIES-1:0]   oldest;
	logic                 hit;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     victim_idx;
	logic                 fill;

	rsp_t                 rsp_q;

	// Active entry count, clamped to 1..ENTRIES
	always_comb begin
		act_ext = CAP_W'(active_q);
		if (act_ext == '0)
			cap = CNT_W'(1);
		else if (act_ext > CAP_W'(ENTRIES))
			cap = CNT_W'(ENTRIES);
		else
			cap = CNT_W'(act_ext);
	end

	// Parallel tag compare over filled entries, first match wins
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++)
			match[i] = (CNT_W'(i) < filled_q) && (page_q[i] == req_page_q);
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i])
				hit_idx = IDX_W'(i);
		end
		hit = |match;
	end

	// Oldest entry among the active slots: no other active slot is older
	always_comb begin
		victim_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			oldest[i] = (CNT_W'(i) < cap);
			for (int j = 0; j < ENTRIES; j++) begin
				if ((CNT_W'(j) < cap) && (age_q[j] > age_q[i]))
					oldest[i] = 1'b0;
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (oldest[i])
				victim_idx = IDX_W'(i);
		end
		fill = (filled_q < cap);
	end

	// Recency update: chosen slot to rank 0, younger filled entries (all on a fill) age by one
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (IDX_W'(i) == slot_s1)
				age_nxt[i] = '0;
			else if ((CNT_W'(i) < filled_q) && (fill_s1 || (age_q[i] < age_q[slot_s1])))
				age_nxt[i] = age_q[i] + AGE_W'(1);
			else
				age_nxt[i] = age_q[i];
		end
		misses_nxt = misses_q;
		if (!hit_s1 && (misses_q != '1))
			misses_nxt = misses_q + COUNT_W'(1);
	end

	// Control state: config register, ranks and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			filled_q <= '0;
			misses_q <= '0;
			for (int i = 0; i < ENTRIES; i++)
				age_q[i] <= '0;
		end else begin
			if (cfg_wr_en)
				active_q <= cfg_wr_data;
			// start_new of the incoming word wins over the finishing update
			if (cmd.accept && req.start_new) begin
				filled_q <= '0;
				misses_q <= '0;
				for (int i = 0; i < ENTRIES; i++)
					age_q[i] <= '0;
			end else if (cmd.update) begin
				age_q    <= age_nxt;
				misses_q <= misses_nxt;
				if (fill_s1)
					filled_q <= filled_q + CNT_W'(1);
			end
		end
	end

	// Request capture and lookup results
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_page_q <= PAGE_BITS'(req.page);
			req_last_q <= req.last_request;
		end
		if (cmd.lookup) begin
			hit_s1  <= hit;
			fill_s1 <= !hit && fill;
			if (hit)
				slot_s1 <= hit_idx;
			else if (fill)
				slot_s1 <= IDX_W'(filled_q);
			else
				slot_s1 <= victim_idx;
		end
	end

	// Tag write and response register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (!hit_s1)
				page_q[slot_s1] <= req_page_q;
			rsp_q.hit           <= hit_s1;
			rsp_q.slot          <= SLOT_W'(slot_s1);
			rsp_q.evicted_valid <= !hit_s1 && !fill_s1;
			rsp_q.evicted_page  <= (!hit_s1 && !fill_s1) ? PAGE_W'(page_q[slot_s1]) : '0;
			rsp_q.miss_count    <= misses_nxt;
			rsp_q.run_done      <= req_last_q;
		end
	end

	assign rsp = rsp_q;

endmodule

[src/lpr_checker.sv]
// Port-level checker for the LRU page replacement block, bound to the top level.
module lpr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_wr_en,
	input logic [lpr_pkg::CFG_W-1:0] cfg_wr_data,
	input logic                      req_valid,
	input logic                      req_stall,
	input lpr_pkg::req_t             req,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input lpr_pkg::rsp_t             rsp
);
	import lpr_pkg::*;

	// A stalled response word stays valid and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.evicted_valid)
		else $error("hit word reports an eviction");

	// No eviction means a zero evicted page
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted_valid |-> rsp.evicted_page == '0)
		else $error("evicted page not zero without eviction");

	// Two words are never taken on consecutive edges
	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall || !req_valid)
		else $error("request words accepted back to back");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

[tb/lru_page_replacement_test.sv]
// Self-checking testbench for lru_page_replacement: directed table, then random LRU traffic.
`timescale 1ns / 100ps

module lru_page_replacement_test;
	import lpr_pkg::*;

	localparam int unsigned NUM_ENTRIES    = 16;
	localparam int unsigned WATCHDOG_LIMIT = 500;
	localparam int unsigned POOL_SIZE      = 26;
	localparam int unsigned PHASES         = 13;
	localparam int unsigned PHASE_WORDS    = 100;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	// One line of the directed table
	typedef struct {
		row_kind_t        kind;
		logic [CFG_W-1:0] active;
		req_t             word;
		bit               typed;
		rsp_t             want;
	} script_row_t;

	// Hand-written response attached to a request word, if any
	typedef struct {
		bit   typed;
		rsp_t want;
	} preset_t;

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             req_valid   = 1'b0;
	logic             req_stall;
	req_t             req         = '0;
	logic             rsp_valid;
	logic             rsp_stall   = 1'b0;
	rsp_t             rsp;

	// Mirror of the cache table
	logic [PAGE_W-1:0]  tag_q  [NUM_ENTRIES];
	logic [3:0]         rank_q [NUM_ENTRIES];
	int unsigned        fill_cnt   = 0;
	logic [COUNT_W-1:0] miss_total = '0;
	logic [CFG_W-1:0]   active_cfg = ACTIVE_RESET;

	rsp_t        lookup_results_due [$];
	preset_t     preset_rsp_q [$];
	script_row_t script [$];
	int unsigned fault_cnt = 0;
	int unsigned max_wait  = 16;
	int unsigned quiet_cycles = 0;

	lru_page_replacement #(
		.ENTRIES  (NUM_ENTRIES),
		.PAGE_BITS(PAGE_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Make slot s the newest; entries younger than limit age by one
	function automatic void promote(int unsigned s, int unsigned limit);
		int unsigned i;
		for (i = 0; i < fill_cnt; i++) begin
			if (i != s && rank_q[i] < limit)
				rank_q[i] = rank_q[i] + 4'd1;
		end
		rank_q[s] = '0;
	endfunction

	// Lookup one page, update the mirror table, return the response word
	function automatic rsp_t lru_access(req_t w);
		rsp_t        r;
		int unsigned i, cap, s, best;
		bit          found;
		r = '0;
		s = 0;
		found = 1'b0;
		if (w.start_new) begin
			for (i = 0; i < NUM_ENTRIES; i++) begin
				tag_q[i] = '0;
				rank_q[i] = '0;
			end
			fill_cnt = 0;
			miss_total = '0;
		end
		cap = (active_cfg == 0) ? 1 : ((active_cfg > NUM_ENTRIES) ? NUM_ENTRIES : active_cfg);
		// search every filled entry, even past the active count
		for (i = 0; i < fill_cnt; i++) begin
			if (!found && tag_q[i] == w.page) begin
				found = 1'b1;
				s = i;
			end
		end
		if (found) begin
			promote(s, rank_q[s]);
		end else begin
			if (fill_cnt < cap) begin
				s = fill_cnt;
				tag_q[s] = w.page;
				fill_cnt++;
				promote(s, NUM_ENTRIES);
			end else begin
				// oldest among the active slots only
				best = 0;
				for (i = 0; i < cap; i++) begin
					if (rank_q[i] > rank_q[best])
						best = i;
				end
				s = best;
				r.evicted_valid = 1'b1;
				r.evicted_page = tag_q[s];
				tag_q[s] = w.page;
				promote(s, rank_q[s]);
			end
			if (miss_total != '1)
				miss_total++;
		end
		r.hit = found;
		r.slot = SLOT_W'(s);
		r.miss_count = miss_total;
		r.run_done = w.last_request;
		return r;
	endfunction

	function automatic void add_word(logic [PAGE_W-1:0] pg, logic sn, logic lr, bit typed,
			rsp_t want);
		script_row_t row;
		row.kind = ROW_WORD;
		row.active = '0;
		row.word = '{page: pg, start_new: sn, last_request: lr};
		row.typed = typed;
		row.want = want;
		script.insert(script.size(), row);
	endfunction

	function automatic void add_cfg(logic [CFG_W-1:0] v);
		script_row_t row;
		row.kind = ROW_CFG;
		row.active = v;
		row.word = '0;
		row.typed = 1'b0;
		row.want = '0;
		script.insert(script.size(), row);
	endfunction

	// Drop valid and wait until every response is back
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (lookup_results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_active(logic [CFG_W-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Present one request word after a random gap and wait for it to be taken
	task automatic send_word(req_t w, bit typed, rsp_t want);
		int unsigned gap;
		gap = $urandom_range(0, max_wait);
		preset_rsp_q.insert(preset_rsp_q.size(), preset_t'{typed, want});
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
	endtask

	// Response side: random stall before each word
	initial begin : rsp_sink
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, max_wait);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	// Predict on request accept, compare on response accept
	always @(posedge clk) begin : scoreboard
		rsp_t    exp_w;
		preset_t p;
		if (arst_n) begin
			if (cfg_wr_en)
				active_cfg = cfg_wr_data;
			if (req_valid && !req_stall) begin
				p = preset_rsp_q.pop_front();
				exp_w = lru_access(req);
				lookup_results_due.insert(lookup_results_due.size(),
					p.typed ? p.want : exp_w);
			end
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				if (lookup_results_due.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("unexpected response word: %h", rsp);
				end else begin
					exp_w = lookup_results_due.pop_front();
					if (rsp !== exp_w) begin
						fault_cnt++;
						if (fault_cnt <= 10)
							$display({"mismatch at %0t: expected hit=%b slot=%0d ev=%b evp=%h ",
								"miss=%0d done=%b, got hit=%b slot=%0d ev=%b evp=%h miss=%0d done=%b"},
								$time, exp_w.hit, exp_w.slot, exp_w.evicted_valid,
								exp_w.evicted_page, exp_w.miss_count, exp_w.run_done,
								rsp.hit, rsp.slot, rsp.evicted_valid, rsp.evicted_page,
								rsp.miss_count, rsp.run_done);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("lru_page_replacement regression: fail");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		logic [PAGE_W-1:0] page_pool [POOL_SIZE];
		logic [CFG_W-1:0]  act;
		int unsigned       ph, n, k, span;
		req_t              w;

		// directed table: reset state, extremes, clear, run end, odd active counts
		add_word(32'h0000_0000, 1'b1, 1'b0, 1'b1, rsp_t'{1'b0, 4'd0, 1'b0, 32'h0, 32'd1, 1'b0});
		add_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, rsp_t'{1'b0, 4'd1, 1'b0, 32'h0, 32'd2, 1'b0});
		add_word(32'h0000_0000, 1'b0, 1'b1, 1'b1, rsp_t'{1'b1, 4'd0, 1'b0, 32'h0, 32'd2, 1'b1});
		add_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, rsp_t'{1'b1, 4'd1, 1'b0, 32'h0, 32'd2, 1'b0});
		// active count below the fill level: replace inside slot 0, still hit slot 1
		add_cfg(5'd1);
		add_word(32'h0000_0005, 1'b0, 1'b0, 1'b1, rsp_t'{1'b0, 4'd0, 1'b1, 32'h0, 32'd3, 1'b0});
		add_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, rsp_t'{1'b1, 4'd1, 1'b0, 32'h0, 32'd3, 1'b0});
		// zero acts as one
		add_cfg(5'd0);
		add_word(32'h0000_0006, 1'b0, 1'b0, 1'b1, rsp_t'{1'b0, 4'd0, 1'b1, 32'h5, 32'd4, 1'b0});
		// above the entry count saturates
		add_cfg(5'd31);
		add_word(32'h0000_0007, 1'b1, 1'b0, 1'b1, rsp_t'{1'b0, 4'd0, 1'b0, 32'h0, 32'd1, 1'b0});
		add_word(32'h8000_0000, 1'b0, 1'b0, 1'b1, rsp_t'{1'b0, 4'd1, 1'b0, 32'h0, 32'd2, 1'b0});
		add_cfg(5'd2);
		add_word(32'h0000_0009, 1'b0, 1'b0, 1'b1, rsp_t'{1'b0, 4'd0, 1'b1, 32'h7, 32'd3, 1'b0});
		add_word(32'h0000_0007, 1'b0, 1'b0, 1'b1,
			rsp_t'{1'b0, 4'd1, 1'b1, 32'h8000_0000, 32'd4, 1'b0});
		add_cfg(5'd17);
		add_word(32'hA5A5_A5A5, 1'b0, 1'b0, 1'b1, rsp_t'{1'b0, 4'd2, 1'b0, 32'h0, 32'd5, 1'b0});
		add_word(32'h5A5A_5A5A, 1'b0, 1'b1, 1'b1, rsp_t'{1'b0, 4'd3, 1'b0, 32'h0, 32'd6, 1'b1});
		add_word(32'h0000_0009, 1'b0, 1'b0, 1'b1, rsp_t'{1'b1, 4'd0, 1'b0, 32'h0, 32'd6, 1'b0});
		add_word(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0);
		add_word(32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, '0);
		add_word(32'h0000_0005, 1'b0, 1'b0, 1'b0, '0);
		add_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, rsp_t'{1'b0, 4'd0, 1'b0, 32'h0, 32'd1, 1'b1});
		add_cfg(5'd16);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				set_active(script[i].active);
			else
				send_word(script[i].word, script[i].typed, script[i].want);
		end

		// random phases, each under its own active count; no clear at phase start
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: act = 5'd16;
				1: act = 5'd1;
				2: act = 5'd5;
				3: act = 5'd0;
				4: act = 5'd31;
				5: act = 5'd3;
				6: act = 5'd16;
				7: act = 5'd8;
				8: act = 5'd17;
				9: act = 5'd2;
				10: act = 5'd12;
				default: act = CFG_W'($urandom_range(0, 31));
			endcase
			set_active(act);
			for (k = 0; k < POOL_SIZE; k++)
				page_pool[k] = $urandom;
			span = (act == 0) ? 1 : ((act > NUM_ENTRIES) ? NUM_ENTRIES : act);
			span = span + span / 2 + 1;
			for (n = 0; n < PHASE_WORDS; n++) begin
				// stretches with and without idling on both sides
				if (n % 25 == 0)
					max_wait = ($urandom_range(0, 3) == 0) ? 0 : 16;
				// mostly a small working set so hits and evictions both occur
				if ($urandom_range(0, 99) < 88)
					w.page = page_pool[$urandom_range(0, span)];
				else
					w.page = $urandom;
				w.start_new = ($urandom_range(0, 59) == 0);
				w.last_request = ($urandom_range(0, 7) == 0);
				send_word(w, 1'b0, '0);
			end
		end

		settle();
		if (fault_cnt == 0 && lookup_results_due.size() == 0)
			$display("lru_page_replacement regression: pass");
		else
			$display("lru_page_replacement regression: fail");
		$finish;
	end

endmodule

[lru_page_replacement.f]
src/lpr_pkg.sv
src/lpr_ctrl.sv
src/lpr_dp.sv
src/lru_page_replacement.sv
src/lpr_checker.sv
tb/lru_page_replacement_test.sv
